@@ rtl/core/lhmd_pkg.sv @@
`default_nettype none
package lhmd_pkg;

    // Table dimensions.
    localparam int MAX_LEN        = 256;
    localparam int MAX_CHECKS     = 128;
    localparam int MAX_ROW_WEIGHT = 8;
    localparam int MAX_COL_WEIGHT = 4;

    localparam int CC_DEPTH = MAX_CHECKS * MAX_ROW_WEIGHT;
    localparam int BC_DEPTH = MAX_LEN * MAX_COL_WEIGHT;
    localparam int CC_AW    = $clog2(CC_DEPTH);
    localparam int BC_AW    = $clog2(BC_DEPTH);
    localparam int WB_AW    = $clog2(MAX_LEN);

    // Item commands.
    localparam logic [2:0] CMD_LOAD_CHECK = 3'd0;
    localparam logic [2:0] CMD_LOAD_BIT   = 3'd1;
    localparam logic [2:0] CMD_LOAD_WORD  = 3'd2;
    localparam logic [2:0] CMD_DECODE     = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_CODE_LENGTH    = 3'd0;
    localparam logic [2:0] REG_NUM_CHECKS     = 3'd1;
    localparam logic [2:0] REG_ROW_WEIGHT     = 3'd2;
    localparam logic [2:0] REG_COLUMN_WEIGHT  = 3'd3;
    localparam logic [2:0] REG_MAX_ITERATIONS = 3'd4;

    typedef struct packed {
        logic [8:0] code_length;
        logic [7:0] num_checks;
        logic [3:0] row_weight;
        logic [2:0] column_weight;
        logic [7:0] max_iterations;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/lhmd_ram.sv @@
`default_nettype none
module lhmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/core/lhmd_seq.sv @@
`default_nettype none
module lhmd_seq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lhmd_pkg::cfg_t         cfg,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic [2:0]             cmd,
    input  wire logic [7:0]             index,
    input  wire logic [2:0]             slot,
    input  wire logic [7:0]             value,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic                        decoded_bit,
    output logic                        success,
    output logic [7:0]                  sweeps_used,
    output logic                        cc_we,
    output logic [lhmd_pkg::CC_AW-1:0]  cc_waddr,
    output logic [7:0]                  cc_wdata,
    output logic [lhmd_pkg::CC_AW-1:0]  cc_raddr,
    input  wire logic [7:0]             cc_rdata,
    output logic                        bc_we,
    output logic [lhmd_pkg::BC_AW-1:0]  bc_waddr,
    output logic [6:0]                  bc_wdata,
    output logic [lhmd_pkg::BC_AW-1:0]  bc_raddr,
    input  wire logic [6:0]             bc_rdata,
    output logic                        wb_we,
    output logic [lhmd_pkg::WB_AW-1:0]  wb_waddr,
    output logic                        wb_wdata,
    output logic [lhmd_pkg::WB_AW-1:0]  wb_raddr,
    input  wire logic                   wb_rdata
);
    import lhmd_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_READ       = 4'd1;
    localparam logic [3:0] S_BIT        = 4'd2;
    localparam logic [3:0] S_CUR_W      = 4'd3;
    localparam logic [3:0] S_CHK        = 4'd4;
    localparam logic [3:0] S_BC_W       = 4'd5;
    localparam logic [3:0] S_COL        = 4'd6;
    localparam logic [3:0] S_CC_W       = 4'd7;
    localparam logic [3:0] S_WB_W       = 4'd8;
    localparam logic [3:0] S_UPD        = 4'd9;
    localparam logic [3:0] S_SYN_ROW    = 4'd10;
    localparam logic [3:0] S_SYN_COL    = 4'd11;
    localparam logic [3:0] S_SYN_CC_W   = 4'd12;
    localparam logic [3:0] S_SYN_WB_W   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [8:0] bit_reg, bit_next;
    logic [2:0] j_reg, j_next;
    logic [3:0] k_reg, k_next;
    logic [6:0] row_reg, row_next;
    logic [7:0] r_reg, r_next;
    logic [7:0] col_reg, col_next;
    logic [2:0] ones_reg, ones_next;
    logic       par_reg, par_next;
    logic [7:0] used_reg, used_next;
    logic       rv_reg, rv_next;
    logic       rbit_reg, rbit_next;
    logic       rok_reg, rok_next;
    logic [7:0] rused_reg, rused_next;

    logic [8:0] len;
    logic [7:0] nc;
    logic [3:0] rw;
    logic [2:0] cw;
    logic       accept;
    logic [3:0] twice_ones;
    logic [3:0] votes;

    // Register values clipped to the table sizes.
    assign len = (cfg.code_length > 9'(MAX_LEN)) ? 9'(MAX_LEN) : cfg.code_length;
    assign nc  = (cfg.num_checks > 8'(MAX_CHECKS)) ? 8'(MAX_CHECKS) : cfg.num_checks;
    assign rw  = (cfg.row_weight > 4'(MAX_ROW_WEIGHT)) ? 4'(MAX_ROW_WEIGHT) : cfg.row_weight;
    assign cw  = (cfg.column_weight > 3'(MAX_COL_WEIGHT)) ? 3'(MAX_COL_WEIGHT)
                                                          : cfg.column_weight;

    // Items wait while busy; decode and read items also wait until the result register is free.
    assign item_stall = (state_reg != S_IDLE) ||
                        (rv_reg && (cmd inside {CMD_DECODE, CMD_READ}));
    assign accept     = item_valid && !item_stall;

    assign twice_ones = {ones_reg, 1'b0};
    assign votes      = {1'b0, cw} + 4'd1;

    // Table writes from load items.
    always_comb
    begin
        cc_we    = accept && (cmd == CMD_LOAD_CHECK) && (index < 8'(MAX_CHECKS));
        cc_waddr = {index[6:0], slot};
        cc_wdata = value;
        bc_we    = accept && (cmd == CMD_LOAD_BIT) && (slot < 3'(MAX_COL_WEIGHT));
        bc_waddr = {index, slot[1:0]};
        bc_wdata = value[6:0];
    end

    // Word memory port: load writes, in-place bit updates, and reads; also the table read addresses.
    always_comb
    begin
        wb_we    = 1'b0;
        wb_waddr = index;
        wb_wdata = value[0];
        if (accept && (cmd == CMD_LOAD_WORD))
        begin
            wb_we = 1'b1;
        end
        else if (state_reg == S_UPD)
        begin
            wb_waddr = bit_reg[7:0];
            wb_wdata = (twice_ones > votes);
            wb_we    = (twice_ones != votes);
        end

        case (state_reg)
            S_BIT:                wb_raddr = bit_reg[7:0];
            S_CC_W, S_SYN_CC_W:   wb_raddr = cc_rdata;
            default:              wb_raddr = index;
        endcase

        if (state_reg == S_SYN_COL)
        begin
            cc_raddr = {r_reg[6:0], k_reg[2:0]};
        end
        else
        begin
            cc_raddr = {row_reg, k_reg[2:0]};
        end
        bc_raddr = {bit_reg[7:0], j_reg[1:0]};
    end

    // Decode and read sequencer.
    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        r_next     = r_reg;
        col_next   = col_reg;
        ones_next  = ones_reg;
        par_next   = par_reg;
        used_next  = used_reg;
        rv_next    = rv_reg && result_stall;
        rbit_next  = rbit_reg;
        rok_next   = rok_reg;
        rused_next = rused_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_READ))
                begin
                    state_next = S_READ;
                end
                else if (accept && (cmd == CMD_DECODE))
                begin
                    used_next = 8'd0;
                    bit_next  = 9'd0;
                    r_next    = 8'd0;
                    if (cfg.max_iterations == 8'd0)
                    begin
                        state_next = S_SYN_ROW;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
            end
            S_READ:
            begin
                rv_next    = 1'b1;
                rbit_next  = wb_rdata;
                rok_next   = 1'b0;
                rused_next = 8'd0;
                state_next = S_IDLE;
            end
            S_BIT:
            begin
                if (bit_reg == len)
                begin
                    used_next  = used_reg + 8'd1;
                    r_next     = 8'd0;
                    state_next = S_SYN_ROW;
                end
                else
                begin
                    state_next = S_CUR_W;
                end
            end
            S_CUR_W:
            begin
                ones_next  = {2'b00, wb_rdata};
                j_next     = 3'd0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (j_reg == cw)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    state_next = S_BC_W;
                end
            end
            S_BC_W:
            begin
                row_next   = bc_rdata;
                k_next     = 4'd0;
                par_next   = 1'b0;
                state_next = S_COL;
            end
            S_COL:
            begin
                if (k_reg == rw)
                begin
                    ones_next  = ones_reg + {2'b00, par_reg};
                    j_next     = j_reg + 3'd1;
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_CC_W;
                end
            end
            S_CC_W:
            begin
                col_next   = cc_rdata;
                state_next = S_WB_W;
            end
            S_WB_W:
            begin
                // The bit being voted on is left out of its own checks.
                if (col_reg != bit_reg[7:0])
                begin
                    par_next = par_reg ^ wb_rdata;
                end
                k_next     = k_reg + 4'd1;
                state_next = S_COL;
            end
            S_UPD:
            begin
                bit_next   = bit_reg + 9'd1;
                state_next = S_BIT;
            end
            S_SYN_ROW:
            begin
                if (r_reg == nc)
                begin
                    rv_next    = 1'b1;
                    rbit_next  = 1'b0;
                    rok_next   = 1'b1;
                    rused_next = used_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = 4'd0;
                    par_next   = 1'b0;
                    state_next = S_SYN_COL;
                end
            end
            S_SYN_COL:
            begin
                if (k_reg == rw)
                begin
                    if (!par_reg)
                    begin
                        r_next     = r_reg + 8'd1;
                        state_next = S_SYN_ROW;
                    end
                    else if (used_reg == cfg.max_iterations)
                    begin
                        rv_next    = 1'b1;
                        rbit_next  = 1'b0;
                        rok_next   = 1'b0;
                        rused_next = used_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        bit_next   = 9'd0;
                        state_next = S_BIT;
                    end
                end
                else
                begin
                    state_next = S_SYN_CC_W;
                end
            end
            S_SYN_CC_W:
            begin
                state_next = S_SYN_WB_W;
            end
            S_SYN_WB_W:
            begin
                par_next   = par_reg ^ wb_rdata;
                k_next     = k_reg + 4'd1;
                state_next = S_SYN_COL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    // Counters and result payload.
    always_ff @(posedge clk)
    begin
        bit_reg   <= bit_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        row_reg   <= row_next;
        r_reg     <= r_next;
        col_reg   <= col_next;
        ones_reg  <= ones_next;
        par_reg   <= par_next;
        used_reg  <= used_next;
        rbit_reg  <= rbit_next;
        rok_reg   <= rok_next;
        rused_reg <= rused_next;
    end

    assign result_valid = rv_reg;
    assign decoded_bit  = rbit_reg;
    assign success      = rok_reg;
    assign sweeps_used  = rused_reg;

endmodule
`default_nettype wire

@@ rtl/core/ldpc_hard_majority_decoder.sv @@
// Load items are accepted one per cycle while no decode or read is running; a read result
// passes through the read state into the result register before it is presented. A decode
// item holds the input while its sweeps and syndrome tests run.
// Decode and read items also wait while an earlier result is still held at the output.
// Reset restores the configuration registers to their defaults and empties the result
// register; the three tables are not cleared and hold nothing valid until loaded.
`default_nettype none
module ldpc_hard_majority_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [2:0] cmd,
    input  wire logic [7:0] index,
    input  wire logic [2:0] slot,
    input  wire logic [7:0] value,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            decoded_bit,
    output logic            success,
    output logic [7:0]      sweeps_used
);
    import lhmd_pkg::*;

    cfg_t cfg_reg;

    logic             cc_we, bc_we, wb_we, wb_wdata, wb_rdata;
    logic [CC_AW-1:0] cc_waddr, cc_raddr;
    logic [BC_AW-1:0] bc_waddr, bc_raddr;
    logic [WB_AW-1:0] wb_waddr, wb_raddr;
    logic [7:0]       cc_wdata, cc_rdata;
    logic [6:0]       bc_wdata, bc_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_length    <= 9'd256;
            cfg_reg.num_checks     <= 8'd128;
            cfg_reg.row_weight     <= 4'd6;
            cfg_reg.column_weight  <= 3'd3;
            cfg_reg.max_iterations <= 8'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CODE_LENGTH:    cfg_reg.code_length    <= cfg_data;
                REG_NUM_CHECKS:     cfg_reg.num_checks     <= cfg_data[7:0];
                REG_ROW_WEIGHT:     cfg_reg.row_weight     <= cfg_data[3:0];
                REG_COLUMN_WEIGHT:  cfg_reg.column_weight  <= cfg_data[2:0];
                REG_MAX_ITERATIONS: cfg_reg.max_iterations <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    lhmd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .index        (index),
        .slot         (slot),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .decoded_bit  (decoded_bit),
        .success      (success),
        .sweeps_used  (sweeps_used),
        .cc_we        (cc_we),
        .cc_waddr     (cc_waddr),
        .cc_wdata     (cc_wdata),
        .cc_raddr     (cc_raddr),
        .cc_rdata     (cc_rdata),
        .bc_we        (bc_we),
        .bc_waddr     (bc_waddr),
        .bc_wdata     (bc_wdata),
        .bc_raddr     (bc_raddr),
        .bc_rdata     (bc_rdata),
        .wb_we        (wb_we),
        .wb_waddr     (wb_waddr),
        .wb_wdata     (wb_wdata),
        .wb_raddr     (wb_raddr),
        .wb_rdata     (wb_rdata)
    );

    // Column list of each check.
    lhmd_ram #(.WIDTH(8), .DEPTH(CC_DEPTH)) u_check_columns (
        .clk   (clk),
        .we    (cc_we),
        .waddr (cc_waddr),
        .wdata (cc_wdata),
        .raddr (cc_raddr),
        .rdata (cc_rdata)
    );

    // Check list of each bit.
    lhmd_ram #(.WIDTH(7), .DEPTH(BC_DEPTH)) u_bit_checks (
        .clk   (clk),
        .we    (bc_we),
        .waddr (bc_waddr),
        .wdata (bc_wdata),
        .raddr (bc_raddr),
        .rdata (bc_rdata)
    );

    // Code word bits.
    lhmd_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_word_bits (
        .clk   (clk),
        .we    (wb_we),
        .waddr (wb_waddr),
        .wdata (wb_wdata),
        .raddr (wb_raddr),
        .rdata (wb_rdata)
    );

endmodule
`default_nettype wire
